// ----- rtl/core/drpt_pkg.sv -----
// Package for the dead reckoning pose tracker: operation and register codes,
// angle and confidence constants, the CORDIC arctangent table.
// No dependencies.
package drpt_pkg;

    localparam int CORDIC_ITERATIONS_DEF = 16;
    localparam int FRAC_BITS_DEF         = 16;

    // Heading is always Q9.16 degrees
    localparam int DEG_90  = 90 * 65536;
    localparam int DEG_180 = 180 * 65536;
    localparam int DEG_270 = 270 * 65536;
    localparam int DEG_360 = 360 * 65536;

    localparam logic [16:0] CONF_ONE  = 17'h10000;
    localparam logic [16:0] CONF_HALF = 17'h08000;

    // CORDIC gain 0.6072529350088813 in Q30
    localparam longint GAIN_Q30 = 64'd652032874;

    localparam logic [2:0] OP_ODOM  = 3'd0;
    localparam logic [2:0] OP_LINE  = 3'd1;
    localparam logic [2:0] OP_WAYPT = 3'd2;
    localparam logic [2:0] OP_SET   = 3'd3;
    localparam logic [2:0] OP_RESET = 3'd4;

    localparam logic [2:0] CFG_DECAY_RATE = 3'd0;
    localparam logic [2:0] CFG_TIMEOUT    = 3'd1;
    localparam logic [2:0] CFG_TIME_STEP  = 3'd2;
    localparam logic [2:0] CFG_LINE_BOOST = 3'd3;

    // atan(2^-k) in degrees, Q24
    function automatic logic [29:0] atan_q24(input logic [4:0] k);
        logic [29:0] v;
        case (k)
            5'd0:  v = 30'd754974720;
            5'd1:  v = 30'd445687602;
            5'd2:  v = 30'd235489088;
            5'd3:  v = 30'd119537938;
            5'd4:  v = 30'd60000934;
            5'd5:  v = 30'd30029717;
            5'd6:  v = 30'd15018523;
            5'd7:  v = 30'd7509720;
            5'd8:  v = 30'd3754917;
            5'd9:  v = 30'd1877466;
            5'd10: v = 30'd938734;
            5'd11: v = 30'd469367;
            5'd12: v = 30'd234684;
            5'd13: v = 30'd117342;
            5'd14: v = 30'd58671;
            5'd15: v = 30'd29335;
            5'd16: v = 30'd14668;
            5'd17: v = 30'd7334;
            5'd18: v = 30'd3667;
            5'd19: v = 30'd1833;
            5'd20: v = 30'd917;
            5'd21: v = 30'd458;
            5'd22: v = 30'd229;
            5'd23: v = 30'd115;
            5'd24: v = 30'd57;
            5'd25: v = 30'd29;
            5'd26: v = 30'd14;
            5'd27: v = 30'd7;
            5'd28: v = 30'd4;
            5'd29: v = 30'd2;
            5'd30: v = 30'd1;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/core/drpt_cordic.sv -----
// Iterative rotation-mode CORDIC: cos and sin of a heading in Q9.16 degrees.
// Depends on drpt_pkg (angle constants, gain, arctangent table).
module drpt_cordic #(
    parameter int ITERATIONS = drpt_pkg::CORDIC_ITERATIONS_DEF,
    parameter int FRAC       = drpt_pkg::FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [24:0]          i_angle,
    output logic                 o_done,
    output logic signed [FRAC+2:0] o_cos,
    output logic signed [FRAC+2:0] o_sin
);
    import drpt_pkg::*;

    localparam int CW = FRAC + 3;
    localparam int ZW = 34;
    localparam int IW = (ITERATIONS > 1) ? $clog2(ITERATIONS) : 1;
    localparam logic signed [CW-1:0] X0 =
        CW'((GAIN_Q30 + (64'sd1 <<< (29 - FRAC))) >>> (30 - FRAC));

    logic                 r_busy, r_done, r_neg;
    logic [IW-1:0]        r_iter;
    logic signed [CW-1:0] r_x, r_y;
    logic signed [ZW-1:0] r_z;

    logic signed [25:0]   ang, ang_f;
    logic                 neg_f;
    logic [4:0]           k;
    logic signed [CW-1:0] sh_x, sh_y;
    logic signed [ZW-1:0] at;

    // Fold into -90..90, negating the result for the rear half
    always_comb begin
        ang   = signed'({1'b0, i_angle});
        ang_f = ang;
        neg_f = 1'b0;
        if (ang > DEG_90 && ang <= DEG_270) begin
            ang_f = ang - 26'(DEG_180);
            neg_f = 1'b1;
        end else if (ang > DEG_270) begin
            ang_f = ang - 26'(DEG_360);
        end
    end

    assign k    = 5'(r_iter);
    assign sh_x = r_x >>> k;
    assign sh_y = r_y >>> k;
    assign at   = signed'(ZW'(atan_q24(k)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_iter <= '0;
        end else begin
            r_done <= r_busy && !i_start && (r_iter == IW'(ITERATIONS - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_iter <= '0;
                r_neg  <= neg_f;
                r_x    <= X0;
                r_y    <= '0;
                r_z    <= ZW'(ang_f) <<< 8;
            end else if (r_busy) begin
                if (!r_z[ZW-1]) begin
                    r_x <= r_x - sh_y;
                    r_y <= r_y + sh_x;
                    r_z <= r_z - at;
                end else begin
                    r_x <= r_x + sh_y;
                    r_y <= r_y - sh_x;
                    r_z <= r_z + at;
                end
                if (r_iter == IW'(ITERATIONS - 1)) begin
                    r_busy <= 1'b0;
                end
                r_iter <= r_iter + 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_cos  = r_neg ? -r_x : r_x;
    assign o_sin  = r_neg ? -r_y : r_y;

endmodule

// ----- rtl/core/dead_reckoning_pose_tracker.sv -----
// Dead reckoning pose tracker top level: pose state, heading wrap, bit-serial
// products for position and distance decay. Depends on drpt_pkg, drpt_cordic.
//
//  channel  | direction | handshake                | payload
//  ---------+-----------+--------------------------+-------------------------------
//  in       | request   | i_in_valid / o_in_ready   | operation, time, deltas, pose
//  out      | result    | o_out_valid / i_out_ready | x, y, heading, confidence, dist
//  cfg      | write     | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// An odometry request passes the accept step, the heading wrap, the CORDIC loop,
// the bit-serial multiplier, one finish step and the output load. Other operations
// go from the accept step straight to the output load.
// Reset is synchronous; it restores pose and registers at once.
// A new request is taken while the last result still waits on i_out_ready.
module dead_reckoning_pose_tracker #(
    parameter int CORDIC_ITERATIONS = drpt_pkg::CORDIC_ITERATIONS_DEF,
    parameter int FRAC_BITS         = drpt_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [2:0]         i_operation,
    input  logic [31:0]        i_time_ms,
    input  logic signed [31:0] i_delta_distance,
    input  logic signed [25:0] i_delta_heading,
    input  logic signed [31:0] i_x_in,
    input  logic signed [31:0] i_y_in,
    input  logic [24:0]        i_heading_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_x_out,
    output logic signed [31:0] o_y_out,
    output logic [24:0]        o_heading_out,
    output logic [16:0]        o_confidence_out,
    output logic [31:0]        o_distance_out,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);
    import drpt_pkg::*;

    localparam int CW  = FRAC_BITS + 3;
    localparam int NB  = (CW > 16) ? CW : 16;
    localparam int NBW = $clog2(NB);
    localparam int PW  = 32 + NB;
    localparam logic signed [PW-1:0] RND = PW'(1) <<< (FRAC_BITS - 1);

    typedef enum logic [2:0] {S_IDLE, S_WRAP, S_ROT, S_MUL, S_FIN, S_WAIT} t_state;

    t_state r_state;

    // pose state
    logic signed [31:0] r_pos_x, r_pos_y;
    logic [24:0]        r_heading;
    logic [16:0]        r_conf;
    logic [31:0]        r_total, r_last_line;

    // configuration
    logic [15:0] r_decay_rate;
    logic [31:0] r_timeout;
    logic [16:0] r_time_step, r_line_boost;

    // odometry work registers
    logic signed [26:0]   r_h;
    logic signed [31:0]   r_dist;
    logic                 r_tmo, r_cstart;
    logic signed [NB-1:0] r_mc, r_ms;
    logic [NB-1:0]        r_mr;
    logic signed [PW-1:0] r_md, r_acc_x, r_acc_y;
    logic [47:0]          r_mt, r_acc_d;
    logic [NBW-1:0]       r_cnt;

    // output register
    logic               r_out_valid;
    logic signed [31:0] r_ox, r_oy;
    logic [24:0]        r_oh;
    logic [16:0]        r_oc;
    logic [31:0]        r_od;

    logic                 c_done;
    logic signed [CW-1:0] c_cos, c_sin;

    logic [32:0]          n_absd, n_tot_sum;
    logic [31:0]          n_total;
    logic                 n_tmo;
    logic [17:0]          n_boost_sum;
    logic [16:0]          n_boost;
    logic                 mul_last;
    logic signed [PW-1:0] n_md_neg;
    logic signed [PW-1:0] n_step_x, n_step_y;
    logic signed [PW:0]   n_sum_x, n_sum_y;
    logic signed [31:0]   n_pos_x, n_pos_y;
    logic [31:0]          n_decay;
    logic [16:0]          n_conf1, n_conf2;

    drpt_cordic #(
        .ITERATIONS(CORDIC_ITERATIONS),
        .FRAC      (FRAC_BITS)
    ) u_cordic (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(r_cstart),
        .i_angle(r_heading),
        .o_done (c_done),
        .o_cos  (c_cos),
        .o_sin  (c_sin)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;

    // Distance total, line timeout and line boost are settled when the request is taken
    always_comb begin
        n_absd    = i_delta_distance[31] ? 33'd0 - 33'(i_delta_distance)
                                         : 33'(i_delta_distance);
        n_tot_sum = {1'b0, r_total} + n_absd;
        n_total   = n_tot_sum[32] ? 32'hFFFF_FFFF : n_tot_sum[31:0];
        n_tmo     = (i_time_ms - r_last_line) > r_timeout;
        n_boost_sum = {1'b0, r_conf} + {1'b0, r_line_boost};
        n_boost   = (n_boost_sum > {1'b0, CONF_ONE}) ? CONF_ONE : n_boost_sum[16:0];
    end

    // Final position add with saturation, confidence decay with floor at zero
    always_comb begin
        mul_last = (r_cnt == NBW'(NB - 1));
        n_md_neg = -r_md;
        n_step_x = (r_acc_x + RND) >>> FRAC_BITS;
        n_step_y = (r_acc_y + RND) >>> FRAC_BITS;
        n_sum_x  = (PW + 1)'(r_pos_x) + (PW + 1)'(n_step_x);
        n_sum_y  = (PW + 1)'(r_pos_y) + (PW + 1)'(n_step_y);
        if (&n_sum_x[PW:31] || ~|n_sum_x[PW:31])
            n_pos_x = n_sum_x[31:0];
        else
            n_pos_x = n_sum_x[PW] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        if (&n_sum_y[PW:31] || ~|n_sum_y[PW:31])
            n_pos_y = n_sum_y[31:0];
        else
            n_pos_y = n_sum_y[PW] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        n_decay = r_acc_d[47:16];
        n_conf1 = (n_decay >= 32'(r_conf)) ? 17'd0 : r_conf - n_decay[16:0];
        n_conf2 = n_conf1;
        if (r_tmo)
            n_conf2 = (r_time_step >= n_conf1) ? 17'd0 : n_conf1 - r_time_step;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_cstart     <= 1'b0;
            r_pos_x      <= '0;
            r_pos_y      <= '0;
            r_heading    <= '0;
            r_conf       <= CONF_HALF;
            r_total      <= '0;
            r_last_line  <= '0;
            r_decay_rate <= 16'd655;
            r_timeout    <= 32'd10000;
            r_time_step  <= 17'd655;
            r_line_boost <= 17'd6554;
            r_cnt        <= '0;
        end else begin
            // drop the result once taken, unless a new one is loaded now
            if (r_out_valid && i_out_ready && r_state != S_WAIT)
                r_out_valid <= 1'b0;

            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_DECAY_RATE: r_decay_rate <= i_cfg_data[15:0];
                    CFG_TIMEOUT:    r_timeout    <= i_cfg_data;
                    CFG_TIME_STEP:  r_time_step  <= i_cfg_data[16:0];
                    CFG_LINE_BOOST: r_line_boost <= i_cfg_data[16:0];
                    default: ;
                endcase
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= (i_operation == OP_ODOM) ? S_WRAP : S_WAIT;
                        case (i_operation)
                            OP_ODOM: begin
                                r_h     <= 27'(r_heading) + 27'(i_delta_heading);
                                r_dist  <= i_delta_distance;
                                r_total <= n_total;
                                r_tmo   <= n_tmo;
                            end
                            OP_LINE: begin
                                r_last_line <= i_time_ms;
                                r_conf      <= n_boost;
                            end
                            OP_WAYPT: begin
                                r_pos_x <= i_x_in;
                                r_pos_y <= i_y_in;
                                r_conf  <= CONF_ONE;
                                r_total <= '0;
                            end
                            OP_SET: begin
                                r_pos_x   <= i_x_in;
                                r_pos_y   <= i_y_in;
                                r_heading <= i_heading_in;
                                r_conf    <= CONF_ONE;
                            end
                            OP_RESET: begin
                                r_pos_x   <= '0;
                                r_pos_y   <= '0;
                                r_heading <= '0;
                                r_conf    <= CONF_HALF;
                                r_total   <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                S_WRAP: begin
                    // one subtract or add of a full turn per cycle
                    if (r_h > DEG_360) begin
                        r_h <= r_h - 27'(DEG_360);
                    end else if (r_h < 0) begin
                        r_h <= r_h + 27'(DEG_360);
                    end else begin
                        r_heading <= r_h[24:0];
                        r_cstart  <= 1'b1;
                        r_state   <= S_ROT;
                    end
                end
                S_ROT: begin
                    r_cstart <= 1'b0;
                    if (c_done) begin
                        r_mc    <= NB'(c_cos);
                        r_ms    <= NB'(c_sin);
                        r_mr    <= NB'(r_decay_rate);
                        r_md    <= PW'(r_dist);
                        r_mt    <= 48'(r_total);
                        r_acc_x <= '0;
                        r_acc_y <= '0;
                        r_acc_d <= '0;
                        r_cnt   <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    // one multiplier bit per cycle; the top bit of cos and sin
                    // carries negative weight
                    if (r_mc[0]) r_acc_x <= r_acc_x + (mul_last ? n_md_neg : r_md);
                    if (r_ms[0]) r_acc_y <= r_acc_y + (mul_last ? n_md_neg : r_md);
                    if (r_mr[0]) r_acc_d <= r_acc_d + r_mt;
                    r_mc  <= r_mc >>> 1;
                    r_ms  <= r_ms >>> 1;
                    r_mr  <= r_mr >> 1;
                    r_md  <= r_md <<< 1;
                    r_mt  <= r_mt << 1;
                    r_cnt <= r_cnt + 1'b1;
                    if (mul_last)
                        r_state <= S_FIN;
                end
                S_FIN: begin
                    r_pos_x <= n_pos_x;
                    r_pos_y <= n_pos_y;
                    r_conf  <= n_conf2;
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    // hold the result until the output slot is free
                    if (!r_out_valid || i_out_ready) begin
                        r_ox        <= r_pos_x;
                        r_oy        <= r_pos_y;
                        r_oh        <= r_heading;
                        r_oc        <= r_conf;
                        r_od        <= r_total;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_x_out          = r_ox;
    assign o_y_out          = r_oy;
    assign o_heading_out    = r_oh;
    assign o_confidence_out = r_oc;
    assign o_distance_out   = r_od;

`ifndef SYNTHESIS
    a_conf_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_conf <= CONF_ONE)
        else $error("confidence above one");

    a_heading_wrapped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROT) |-> (32'(r_heading) <= 32'(DEG_360)))
        else $error("heading not wrapped before rotation");

    a_cordic_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_done |-> (r_state == S_ROT))
        else $error("CORDIC finished outside rotation phase");

    a_wait_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WAIT && !r_out_valid) |=> (r_out_valid && r_state == S_IDLE))
        else $error("free output slot not loaded");
`endif

endmodule

// ----- tb/dead_reckoning_pose_tracker_tb.sv -----
// Self-checking testbench for dead_reckoning_pose_tracker: directed and random requests,
// register writes between phases, random idling and a long output hold-off.
// Depends on drpt_pkg and the tracker RTL.
module dead_reckoning_pose_tracker_tb;
    import drpt_pkg::*;

    localparam int  WATCHDOG_LIMIT = 20000;
    localparam int  RESULT_LATENCY = 60;

    typedef struct packed {
        logic [2:0]         operation;
        logic [31:0]        time_ms;
        logic signed [31:0] delta_distance;
        logic signed [25:0] delta_heading;
        logic signed [31:0] x_in;
        logic signed [31:0] y_in;
        logic [24:0]        heading_in;
    } pose_req_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [24:0]        heading;
        logic [16:0]        confidence;
        logic [31:0]        distance;
    } pose_t;

    // DUT signals
    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [2:0]         i_operation;
    logic [31:0]        i_time_ms;
    logic signed [31:0] i_delta_distance;
    logic signed [25:0] i_delta_heading;
    logic signed [31:0] i_x_in;
    logic signed [31:0] i_y_in;
    logic [24:0]        i_heading_in;
    logic               o_out_valid;
    logic               i_out_ready;
    logic signed [31:0] o_x_out;
    logic signed [31:0] o_y_out;
    logic [24:0]        o_heading_out;
    logic [16:0]        o_confidence_out;
    logic [31:0]        o_distance_out;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index;
    logic [31:0]        i_cfg_data;

    dead_reckoning_pose_tracker i_dut (.*);

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Predicted tracker state and registers
    logic signed [31:0] trk_x, trk_y;
    logic [24:0]        trk_heading;
    logic [16:0]        trk_conf;
    logic [31:0]        trk_dist, trk_line_time;
    logic [15:0]        reg_decay_rate;
    logic [31:0]        reg_timeout;
    logic [16:0]        reg_time_step, reg_boost;

    pose_req_t pending_reqs[$];
    pose_t     expected_poses[$];

    int  send_idle_pct, recv_stall_pct, holdoff_cycles;
    int  fail_count, accepted_reqs, checked_poses, idle_cycles;

    // Arctangent of 2^-k in degrees, Q24
    longint atan_deg_q24[16] = '{754974720, 445687602, 235489088, 119537938, 60000934,
        30029717, 15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684,
        117342, 58671, 29335};

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic [16:0] conf_minus(logic [16:0] c, longint d);
        return (d >= longint'(c)) ? 17'd0 : 17'(longint'(c) - d);
    endfunction

    // Rotation-mode CORDIC: cos and sin of a Q16 degree angle, Q16 results
    task automatic cos_sin_q16(input longint ang, output longint cs, output longint sn);
        longint a, xv, yv, zv, nx;
        bit     flip;
        a = ang;
        flip = 0;
        if (a > DEG_90 && a <= DEG_270) begin
            a -= DEG_180;
            flip = 1;
        end else if (a > DEG_270) begin
            a -= DEG_360;
        end
        zv = a * 256;
        xv = (GAIN_Q30 + (64'sd1 <<< 13)) >>> 14;
        yv = 0;
        for (int k = 0; k < 16; k++) begin
            if (zv >= 0) begin
                nx = xv - floor_shift(yv, k);
                yv = yv + floor_shift(xv, k);
                zv -= atan_deg_q24[k];
            end else begin
                nx = xv + floor_shift(yv, k);
                yv = yv - floor_shift(xv, k);
                zv += atan_deg_q24[k];
            end
            xv = nx;
        end
        cs = flip ? -xv : xv;
        sn = flip ? -yv : yv;
    endtask

    // Advance the predicted pose by one request and return the pose after it
    task automatic track_pose(input pose_req_t r, output pose_t p);
        longint h, m, cs, sn, mv_dist, tot, decay;
        logic [31:0] since;
        case (r.operation)
            OP_ODOM: begin
                mv_dist = longint'(r.delta_distance);
                h = longint'(trk_heading) + longint'(r.delta_heading);
                if (h > DEG_360) begin
                    m = h % DEG_360;
                    h = (m == 0) ? DEG_360 : m;
                end else if (h < 0) begin
                    m = h % DEG_360;
                    h = (m < 0) ? m + DEG_360 : m;
                end
                trk_heading = h[24:0];
                cos_sin_q16(h, cs, sn);
                trk_x = clamp32(longint'(trk_x) + ((mv_dist * cs + 32768) >>> 16));
                trk_y = clamp32(longint'(trk_y) + ((mv_dist * sn + 32768) >>> 16));
                tot = longint'(trk_dist) + ((mv_dist < 0) ? -mv_dist : mv_dist);
                trk_dist = (tot > 64'sh0ffffffff) ? 32'hffffffff : tot[31:0];
                decay = (longint'(trk_dist) * longint'(reg_decay_rate)) >>> 16;
                trk_conf = conf_minus(trk_conf, decay);
                since = r.time_ms - trk_line_time;
                if (since > reg_timeout)
                    trk_conf = conf_minus(trk_conf, longint'(reg_time_step));
            end
            OP_LINE: begin
                trk_line_time = r.time_ms;
                trk_conf = (18'(trk_conf) + 18'(reg_boost) > 18'(CONF_ONE)) ? CONF_ONE
                         : trk_conf + reg_boost;
            end
            OP_WAYPT: begin
                trk_x = r.x_in;
                trk_y = r.y_in;
                trk_conf = CONF_ONE;
                trk_dist = '0;
            end
            OP_SET: begin
                trk_x = r.x_in;
                trk_y = r.y_in;
                trk_heading = r.heading_in;
                trk_conf = CONF_ONE;
            end
            OP_RESET: begin
                trk_x = '0;
                trk_y = '0;
                trk_heading = '0;
                trk_conf = CONF_HALF;
                trk_dist = '0;
            end
            default: ;
        endcase
        p = '{trk_x, trk_y, trk_heading, trk_conf, trk_dist};
    endtask

    // Driver: offer queued requests, idle at random between them
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || o_in_ready) begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                pose_req_t r;
                r = pending_reqs.pop_front();
                i_in_valid       <= 1'b1;
                i_operation      <= r.operation;
                i_time_ms        <= r.time_ms;
                i_delta_distance <= r.delta_distance;
                i_delta_heading  <= r.delta_heading;
                i_x_in           <= r.x_in;
                i_y_in           <= r.y_in;
                i_heading_in     <= r.heading_in;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Predict on each accepted request
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) begin
            pose_t p;
            track_pose('{i_operation, i_time_ms, i_delta_distance, i_delta_heading,
                         i_x_in, i_y_in, i_heading_in}, p);
            expected_poses.push_back(p);
            accepted_reqs++;
        end
    end

    // Receiver ready: random stalls, or a long hold-off counted here
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (holdoff_cycles > 0) begin
            holdoff_cycles <= holdoff_cycles - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor: compare each accepted result with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_poses.size() == 0) begin
                $error("unexpected result x=%0d y=%0d", o_x_out, o_y_out);
                fail_count++;
            end else begin
                pose_t e;
                e = expected_poses.pop_front();
                checked_poses++;
                if (o_x_out !== e.x) begin
                    $error("x_out: expected %0d actual %0d", e.x, o_x_out);
                    fail_count++;
                end
                if (o_y_out !== e.y) begin
                    $error("y_out: expected %0d actual %0d", e.y, o_y_out);
                    fail_count++;
                end
                if (o_heading_out !== e.heading) begin
                    $error("heading_out: expected %0d actual %0d", e.heading, o_heading_out);
                    fail_count++;
                end
                if (o_confidence_out !== e.confidence) begin
                    $error("confidence_out: expected %0d actual %0d", e.confidence,
                           o_confidence_out);
                    fail_count++;
                end
                if (o_distance_out !== e.distance) begin
                    $error("distance_out: expected %0d actual %0d", e.distance,
                           o_distance_out);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: count cycles with no handshake on any channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
            || (i_cfg_valid && o_cfg_ready)
            || (pending_reqs.size() == 0 && !i_in_valid && expected_poses.size() == 0))
        begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout: %0d requests still queued, %0d results outstanding",
                         pending_reqs.size(), expected_poses.size());
                $display("dead_reckoning_pose_tracker regression: fail");
                $finish;
            end
        end
    end

    function automatic logic signed [31:0] rand_word();
        case ($urandom_range(5))
            0:       return 32'sh7fffffff;
            1:       return 32'sh80000000;
            2:       return $urandom_range(0, 1) ? 32'sd0 : -32'sd1;
            default: return $urandom();
        endcase
    endfunction

    function automatic pose_req_t rand_req();
        pose_req_t r;
        int pick;
        pick = $urandom_range(99);
        r.operation = (pick < 55) ? OP_ODOM : (pick < 72) ? OP_LINE : (pick < 80) ? OP_WAYPT
                    : (pick < 90) ? OP_SET : (pick < 95) ? OP_RESET : 3'($urandom_range(5, 7));
        r.time_ms = $urandom();
        // mostly moderate motion; occasionally full-range
        r.delta_distance = ($urandom_range(9) == 0) ? rand_word()
                         : 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
        r.delta_heading  = 26'($signed($urandom_range(0, 47185920)) - 23592960);
        if ($urandom_range(9) == 0) r.delta_heading = 26'($urandom());
        r.x_in = rand_word();
        r.y_in = rand_word();
        r.heading_in = ($urandom_range(7) == 0) ? 25'($urandom()) : 25'($urandom_range(0, DEG_360));
        return r;
    endfunction

    function automatic pose_req_t make_req(logic [2:0] op, logic [31:0] t, logic [31:0] d,
                                           logic [25:0] dh, logic [31:0] xv, logic [31:0] yv,
                                           logic [24:0] hv);
        pose_req_t r;
        r = '{op, t, d, dh, xv, yv, hv};
        return r;
    endfunction

    // Write one register while the block is idle
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_DECAY_RATE: reg_decay_rate = val[15:0];
            CFG_TIMEOUT:    reg_timeout    = val;
            CFG_TIME_STEP:  reg_time_step  = val[16:0];
            CFG_LINE_BOOST: reg_boost      = val[16:0];
            default: ;
        endcase
    endtask

    // Hold until every queued request is out and every result has come back
    task automatic drain();
        wait (pending_reqs.size() == 0 && !i_in_valid && expected_poses.size() == 0);
        repeat (RESULT_LATENCY) @(posedge i_clk);
    endtask

    task automatic run_phase(int n, int idle_pct, int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (n) pending_reqs.push_back(rand_req());
        drain();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_out_ready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_operation = '0;
        i_time_ms = '0;
        i_delta_distance = '0;
        i_delta_heading = '0;
        i_x_in = '0;
        i_y_in = '0;
        i_heading_in = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        holdoff_cycles = 0;
        fail_count = 0;
        accepted_reqs = 0;
        checked_poses = 0;
        idle_cycles = 0;
        trk_x = '0; trk_y = '0; trk_heading = '0; trk_conf = CONF_HALF;
        trk_dist = '0; trk_line_time = '0;
        reg_decay_rate = 16'd655; reg_timeout = 32'd10000;
        reg_time_step = 17'd655; reg_boost = 17'd6554;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: every operation, field extremes, wrap and cap cases
        pending_reqs.push_back(make_req(OP_ODOM, 0, 32'sd65536, 26'sd0, 0, 0, 0));
        pending_reqs.push_back(make_req(OP_ODOM, 20000, 32'sh7fffffff, 26'sd23592960, 0, 0, 0));
        pending_reqs.push_back(make_req(OP_ODOM, 32'hffffffff, 32'sh80000000, -26'sd23592960,
                                        0, 0, 0));
        pending_reqs.push_back(make_req(OP_ODOM, 5, 32'sd65536, 26'sh1ffffff, 0, 0, 0));
        pending_reqs.push_back(make_req(OP_ODOM, 5, 32'sd65536, 26'sh2000000, 0, 0, 0));
        pending_reqs.push_back(make_req(OP_LINE, 32'hffffffff, 0, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(OP_WAYPT, 0, 0, 0, 32'sh7fffffff, 32'sh80000000, 0));
        pending_reqs.push_back(make_req(OP_ODOM, 1, 32'sh7fffffff, 26'sd0, 0, 0, 0));
        pending_reqs.push_back(make_req(OP_SET, 0, 0, 0, 32'sh80000000, 32'sh7fffffff,
                                        25'h1ffffff));
        pending_reqs.push_back(make_req(OP_ODOM, 2, -32'sd65536, 26'sd0, 0, 0, 0));
        pending_reqs.push_back(make_req(OP_SET, 0, 0, 0, 0, 0, 25'(DEG_90)));
        pending_reqs.push_back(make_req(OP_ODOM, 3, 32'sd131072, 26'sd0, 0, 0, 0));
        pending_reqs.push_back(make_req(OP_ODOM, 3, 32'sd131072, 26'(DEG_180), 0, 0, 0));
        pending_reqs.push_back(make_req(OP_ODOM, 3, 32'sd131072, 26'(DEG_90), 0, 0, 0));
        pending_reqs.push_back(make_req(OP_RESET, 0, 0, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(3'd5, 0, 0, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(3'd7, 32'hffffffff, -1, -1, -1, -1, 25'h1ffffff));
        pending_reqs.push_back(make_req(OP_LINE, 100, 0, 0, 0, 0, 0));
        drain();

        // Extreme registers: full boost and step, zero timeout, max decay
        write_reg(CFG_LINE_BOOST, 32'd65536);
        write_reg(CFG_TIME_STEP, 32'd65536);
        write_reg(CFG_TIMEOUT, 32'd0);
        write_reg(CFG_DECAY_RATE, 32'd65535);
        pending_reqs.push_back(make_req(OP_LINE, 7, 0, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(OP_ODOM, 8, 32'sd1, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(OP_LINE, 9, 0, 0, 0, 0, 0));
        run_phase(150, 0, 0);

        // Zero registers, maximum timeout
        write_reg(CFG_DECAY_RATE, 32'd0);
        write_reg(CFG_TIMEOUT, 32'hffffffff);
        write_reg(CFG_TIME_STEP, 32'd0);
        write_reg(CFG_LINE_BOOST, 32'd0);
        run_phase(150, 47, 0);

        // Random register values
        write_reg(CFG_DECAY_RATE, $urandom_range(0, 2000));
        write_reg(CFG_TIMEOUT, $urandom());
        write_reg(CFG_TIME_STEP, 32'($urandom_range(0, 65536)));
        write_reg(CFG_LINE_BOOST, 32'($urandom_range(0, 65536)));
        run_phase(150, 0, 47);

        // Long output hold-off while requests keep coming: back up the block
        holdoff_cycles = 600;
        run_phase(100, 0, 0);

        write_reg(CFG_DECAY_RATE, 32'd655);
        write_reg(CFG_TIMEOUT, 32'd10000);
        write_reg(CFG_TIME_STEP, 32'd655);
        write_reg(CFG_LINE_BOOST, 32'd6554);
        run_phase(250, 22, 22);

        $display("covered %0d requests, %0d results checked, over four register settings",
                 accepted_reqs, checked_poses);
        $display("phases: no idling, sender idle, receiver stall, long hold-off, both idle");
        if (fail_count == 0) begin
            $display("dead_reckoning_pose_tracker regression: pass");
        end else begin
            $display("dead_reckoning_pose_tracker regression: fail");
        end
        $finish;
    end
endmodule

// ----- files.f -----
rtl/core/drpt_pkg.sv
rtl/core/drpt_cordic.sv
rtl/core/dead_reckoning_pose_tracker.sv
tb/dead_reckoning_pose_tracker_tb.sv
